// ===== src/address_keyed_hash_table_assert.svh =====
// Assertion macros used by the hash table RTL.
`ifndef ADDRESS_KEYED_HASH_TABLE_ASSERT_SVH
`define ADDRESS_KEYED_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hash table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hash table assertion failed");

`endif

// ===== src/aht_pkg.sv =====
package aht_pkg;

    localparam int unsigned HASH_BITS    = 14;
    localparam int unsigned SLOT_COUNT   = 1 << HASH_BITS;
    localparam int unsigned SYMBOL_LIMIT = 8192;
    localparam int unsigned CNT_W        = $clog2(SYMBOL_LIMIT + 1);
    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned SYM_W        = 13;
    localparam int unsigned STATUS_W     = 2;

    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_LOOKUP   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STORE_FULL = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [SYM_W-1:0]  symbol;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // Sign-extended top nibble plus arithmetic shift by 14 plus address, folded to slot count.
    function automatic logic [HASH_BITS-1:0] slot_hash(input logic [ADDR_W-1:0] a);
        logic signed [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0]        top;
        logic [ADDR_W-1:0]        mid;
        logic [ADDR_W-1:0]        sum;
        sa  = signed'(a);
        top = unsigned'(sa >>> 28);
        mid = unsigned'(sa >>> 14);
        sum = top + mid + a;
        return sum[HASH_BITS-1:0];
    endfunction

endpackage

// ===== src/address_keyed_hash_table.sv =====
//  channel | direction | ports                                        | transfer when
//  --------+-----------+----------------------------------------------+-------------------
//  request | in        | s_valid s_ready s_req_type s_address         | s_valid & s_ready
//  result  | out       | m_valid m_ready m_found m_symbol_index m_status | m_valid & m_ready
//
//  After reset, sweep the slot memory one slot a cycle over all SLOT_COUNT (16384) slots
//  with s_ready low; reset itself is synchronous and active low.
//  A request probes slots one per cycle through the single read port, and the next
//  request can transfer only once its probe has finished and the block is idle again.
//  One request is in flight at a time; the result register lets the next request
//  transfer while a finished result waits, and a stalled result holds the probe in place.
`include "address_keyed_hash_table_assert.svh"

module address_keyed_hash_table
    import aht_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [ADDR_W-1:0]    s_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_found,
    output logic [SYM_W-1:0]     m_symbol_index,
    output logic [STATUS_W-1:0]  m_status
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } state_t;

    state_t                state_reg, state_next;
    logic [HASH_BITS-1:0]  clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  type_reg, type_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic                  sym_full_reg, sym_full_next;
    logic [HASH_BITS-1:0]  probe_addr_reg, probe_addr_next;
    logic [HASH_BITS-1:0]  probe_cnt_reg, probe_cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_found_reg, m_found_next;
    logic [SYM_W-1:0]      m_sym_reg, m_sym_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;

    // memory port signals
    logic                  ram_we;
    logic [HASH_BITS-1:0]  ram_waddr;
    logic [HASH_BITS-1:0]  ram_raddr;
    entry_t                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd_entry;

    // probe decision
    logic                  out_busy;
    logic                  probe_done;
    logic                  res_found;
    logic [SYM_W-1:0]      res_sym;
    logic [STATUS_W-1:0]   res_status;
    logic                  res_write;
    logic                  finish;
    logic                  advance;
    logic                  s_xfer;

    assign rd_entry = entry_t'(ram_rdata);
    assign out_busy = m_valid_reg && !m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;

    // Evaluate the slot whose data arrived this cycle.
    always_comb begin
        probe_done = 1'b1;
        res_found  = 1'b0;
        res_sym    = '0;
        res_status = STATUS_OK;
        res_write  = 1'b0;
        priority if (sym_full_reg) begin
            res_status = STATUS_STORE_FULL;
        end else if (!rd_entry.valid) begin
            // empty slot: claim it on register, end of chain on lookup
            if (type_reg == REQ_REGISTER) begin
                res_found = 1'b1;
                res_sym   = SYM_W'(count_reg);
                res_write = 1'b1;
            end
        end else if (type_reg == REQ_LOOKUP && rd_entry.address == addr_reg) begin
            res_found = 1'b1;
            res_sym   = rd_entry.symbol;
        end else if (probe_cnt_reg == '1) begin
            // wrapped all the way around without a free slot or a hit
            res_status = STATUS_TABLE_FULL;
        end else begin
            probe_done = 1'b0;
        end
    end

    assign finish  = (state_reg == ST_PROBE) && probe_done && !out_busy;
    assign advance = (state_reg == ST_PROBE) && !probe_done;

    // Read the next slot ahead while probing; re-read the current one while the
    // result register is blocked so its data stays on the read port.
    always_comb begin
        unique case (state_reg)
            ST_IDLE:  ram_raddr = slot_hash(s_address);
            ST_PROBE: ram_raddr = advance ? probe_addr_reg + 1'b1 : probe_addr_reg;
            default:  ram_raddr = '0;
        endcase
    end

    always_comb begin
        ram_we            = 1'b0;
        ram_waddr         = probe_addr_reg;
        ram_wdata.valid   = 1'b1;
        ram_wdata.address = addr_reg;
        ram_wdata.symbol  = SYM_W'(count_reg);
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (finish && res_write) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        count_next      = count_reg;
        type_next       = type_reg;
        addr_next       = addr_reg;
        sym_full_next   = sym_full_reg;
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        m_found_next    = m_found_reg;
        m_sym_next      = m_sym_reg;
        m_status_next   = m_status_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    type_next       = s_req_type;
                    addr_next       = s_address;
                    sym_full_next   = (s_req_type == REQ_REGISTER)
                                      && (count_reg >= CNT_W'(SYMBOL_LIMIT));
                    probe_addr_next = slot_hash(s_address);
                    probe_cnt_next  = '0;
                    state_next      = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (advance) begin
                    probe_addr_next = probe_addr_reg + 1'b1;
                    probe_cnt_next  = probe_cnt_reg + 1'b1;
                end else if (finish) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found;
                    m_sym_next    = res_sym;
                    m_status_next = res_status;
                    if (res_write) begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
        type_reg       <= type_next;
        addr_reg       <= addr_next;
        sym_full_reg   <= sym_full_next;
        probe_addr_reg <= probe_addr_next;
        probe_cnt_reg  <= probe_cnt_next;
        m_found_reg    <= m_found_next;
        m_sym_reg      <= m_sym_next;
        m_status_reg   <= m_status_next;
    end

    aht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_symbol_index = m_sym_reg;
    assign m_status       = m_status_reg;

    // Slot memory is written only by the clearing sweep or by a finishing register probe.
    `AHT_ASSERT_IMPL(a_write_source, aclk, aresetn, ram_we,
        (state_reg == ST_CLEAR) || (finish && res_write))
    // A finished probe never overwrites a result that is still waiting.
    `AHT_ASSERT_IMPL(a_no_result_overwrite, aclk, aresetn, finish, !out_busy)
    // The symbol count never passes the store limit.
    `AHT_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(SYMBOL_LIMIT))
    // Each slot claimed adds exactly one symbol number.
    `AHT_ASSERT_NEXT(a_count_step, aclk, aresetn, finish && res_write,
        count_reg == $past(count_reg) + 1'b1)
    // A stalled result channel freezes the probe position.
    `AHT_ASSERT_NEXT(a_stall_holds_probe, aclk, aresetn,
        (state_reg == ST_PROBE) && probe_done && out_busy,
        $stable(probe_addr_reg))

endmodule

// ===== src/aht_ram.sv =====
module aht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
